[hdl/uusa_pkg.sv]
package uusa_pkg;

  localparam int FIELD_WIDTH  = 32;
  localparam int TAXA_WIDTH   = 24;
  localparam int WEIGHT_WIDTH = 32;
  localparam int SKIP_WIDTH   = 16;

  typedef enum logic [1:0] {
    CLS_NONE,
    CLS_UNIQUE,
    CLS_SHARED,
    CLS_ROOT
  } split_cls_t;

  typedef struct packed {
    logic       skip;
    split_cls_t cls;
  } split_class_t;

endpackage

[hdl/uusa_classify.sv]
module uusa_classify
  import uusa_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic [COUNT_WIDTH-1:0] left_a,
  input  logic [COUNT_WIDTH-1:0] tot_a,
  input  logic [COUNT_WIDTH-1:0] left_b,
  input  logic [COUNT_WIDTH-1:0] tot_b,
  input  logic [COUNT_WIDTH-1:0] left_o,
  input  logic [COUNT_WIDTH-1:0] tot_o,
  input  logic [TAXA_WIDTH-1:0]  taxa_l,
  input  logic [TAXA_WIDTH-1:0]  taxa_r,
  output split_class_t           result
);

  localparam int SW = COUNT_WIDTH + 2;
  localparam int TW = (COUNT_WIDTH > TAXA_WIDTH) ? COUNT_WIDTH : TAXA_WIDTH;

  logic signed [SW-1:0] ra;
  logic signed [SW-1:0] rb;
  logic signed [SW-1:0] ro;
  logic signed [SW-1:0] rsum;
  logic                 ra_pos, rb_pos, ro_pos, ra_zero, rb_zero;
  logic                 la_pos, lb_pos, lo_pos;
  logic                 ing_l, ing_r;

  assign ra   = $signed({2'b00, tot_a}) - $signed({2'b00, left_a});
  assign rb   = $signed({2'b00, tot_b}) - $signed({2'b00, left_b});
  assign ro   = $signed({2'b00, tot_o}) - $signed({2'b00, left_o});
  assign rsum = ra + rb;

  assign ra_pos  = !ra[SW-1] && (ra != '0);
  assign rb_pos  = !rb[SW-1] && (rb != '0);
  assign ro_pos  = !ro[SW-1] && (ro != '0);
  assign ra_zero = (ra == '0);
  assign rb_zero = (rb == '0);
  assign la_pos  = (left_a != '0);
  assign lb_pos  = (left_b != '0);
  assign lo_pos  = (left_o != '0);

  // ingroup taxa on the outgroup side must be positive
  assign ing_l = TW'(taxa_l) > TW'(left_o);
  assign ing_r = TW'(taxa_r) > TW'(ro[COUNT_WIDTH-1:0]);

  always_comb begin
    result.skip = 1'b0;
    result.cls  = CLS_NONE;
    if (lo_pos && ro_pos) begin
      result.skip = 1'b1;
    end else if (lo_pos) begin
      if ((ra_pos && rb_zero) || (ra_zero && rb_pos)) begin
        result.cls = CLS_UNIQUE;
      end else if (ra_pos && rb_pos && (la_pos || lb_pos)) begin
        result.cls = CLS_SHARED;
      end else if (!la_pos && !lb_pos && ing_l) begin
        result.cls = CLS_ROOT;
      end
    end else if (ro_pos) begin
      if ((la_pos && !lb_pos) || (!la_pos && lb_pos)) begin
        result.cls = CLS_UNIQUE;
      end else if (la_pos && lb_pos && !rsum[SW-1] && (rsum != '0)) begin
        result.cls = CLS_SHARED;
      end else if (ra_zero && rb_zero && ing_r) begin
        result.cls = CLS_ROOT;
      end
    end
  end

endmodule

[hdl/unweighted_unifrac_split_accumulator_core.sv]
// Unweighted UniFrac accumulator for one sample pair. Each accepted split is
// classified against the outgroup side and its Q16.16 weight is added to the
// unique, shared or root sum (saturating); splits with outgroup on both sides
// are counted. A split passes through the capture, classify and accumulate
// steps. A split marked last additionally forms the denominator and runs a
// restoring fraction divide, skipped when the denominator is zero, after
// which one request with distance = floor(unique*2^FRAC_BITS/den) is
// posted and all sums clear. Accumulation, the denominator and the divide
// go through one shared add/subtract unit, one operation per cycle. A
// posted result may wait in the output register while the next split is taken
// in. No clearing pass is needed after reset.
module unweighted_unifrac_split_accumulator_core
  import uusa_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int ACC_WIDTH   = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_a,
  input  logic [FIELD_WIDTH-1:0]  in_total_a,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_b,
  input  logic [FIELD_WIDTH-1:0]  in_total_b,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_out,
  input  logic [FIELD_WIDTH-1:0]  in_total_out,
  input  logic [TAXA_WIDTH-1:0]   in_taxa_left,
  input  logic [TAXA_WIDTH-1:0]   in_taxa_right,
  input  logic [WEIGHT_WIDTH-1:0] in_split_weight,
  input  logic                    in_last_split,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [FRAC_BITS:0]      out_distance,
  output logic                    out_undefined,
  output logic [SKIP_WIDTH-1:0]   out_skipped_splits
);

  localparam int DENW = (ACC_WIDTH + 2 > 64) ? 64 : ACC_WIDTH + 2;
  localparam int CNTW = $clog2(FRAC_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLS,
    S_ACC,
    S_DEN1,
    S_DEN2,
    S_QINIT,
    S_ROOM,
    S_STEP,
    S_DONE
  } state_t;

  state_t                  state_r;
  logic [COUNT_WIDTH-1:0]  la_r, ta_r, lb_r, tb_r, lo_r, to_r;
  logic [TAXA_WIDTH-1:0]   xl_r, xr_r;
  logic [WEIGHT_WIDTH-1:0] weight_r;
  logic                    last_r;
  split_cls_t              cls_r;
  split_class_t            cls_nxt;
  logic [ACC_WIDTH-1:0]    unique_r, shared_r, root_r;
  logic [SKIP_WIDTH-1:0]   skip_r;
  logic [DENW-1:0]         den_r, rem_r, room_r;
  logic [FRAC_BITS:0]      q_r;
  logic                    undef_r;
  logic [CNTW-1:0]         cnt_r;
  logic                    out_valid_r;
  logic [FRAC_BITS:0]      out_distance_r;
  logic                    out_undefined_r;
  logic [SKIP_WIDTH-1:0]   out_skip_r;

  logic [DENW-1:0]         alu_a, alu_b;
  logic                    alu_sub;
  logic [DENW:0]           alu_res;
  logic [ACC_WIDTH-1:0]    acc_sat;
  logic [DENW-1:0]         den_sat;
  logic                    in_accept, out_free;

  uusa_classify #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_classify (
    .left_a (la_r),
    .tot_a  (ta_r),
    .left_b (lb_r),
    .tot_b  (tb_r),
    .left_o (lo_r),
    .tot_o  (to_r),
    .taxa_l (xl_r),
    .taxa_r (xr_r),
    .result (cls_nxt)
  );

  // shared add/subtract unit; for subtract, top bit set means a >= b
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      S_ACC: begin
        case (cls_r)
          CLS_SHARED: alu_a = DENW'(shared_r);
          CLS_ROOT:   alu_a = DENW'(root_r);
          default:    alu_a = DENW'(unique_r);
        endcase
        alu_b = DENW'(weight_r);
      end
      S_DEN1: begin
        alu_a = DENW'(unique_r);
        alu_b = DENW'(shared_r);
      end
      S_DEN2: begin
        alu_a = den_r;
        alu_b = DENW'(root_r);
      end
      S_QINIT: begin
        alu_a   = DENW'(unique_r);
        alu_b   = den_r;
        alu_sub = 1'b1;
      end
      S_ROOM: begin
        alu_a   = den_r;
        alu_b   = rem_r;
        alu_sub = 1'b1;
      end
      S_STEP: begin
        alu_a   = rem_r;
        alu_b   = room_r;
        alu_sub = 1'b1;
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (DENW + 1)'(alu_sub);
  assign acc_sat = alu_res[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : alu_res[ACC_WIDTH-1:0];
  assign den_sat = alu_res[DENW] ? {DENW{1'b1}} : alu_res[DENW-1:0];

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      unique_r    <= '0;
      shared_r    <= '0;
      root_r      <= '0;
      skip_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            la_r     <= in_left_count_a[COUNT_WIDTH-1:0];
            ta_r     <= in_total_a[COUNT_WIDTH-1:0];
            lb_r     <= in_left_count_b[COUNT_WIDTH-1:0];
            tb_r     <= in_total_b[COUNT_WIDTH-1:0];
            lo_r     <= in_left_count_out[COUNT_WIDTH-1:0];
            to_r     <= in_total_out[COUNT_WIDTH-1:0];
            xl_r     <= in_taxa_left;
            xr_r     <= in_taxa_right;
            weight_r <= in_split_weight;
            last_r   <= in_last_split;
            state_r  <= S_CLS;
          end
        end
        S_CLS: begin
          cls_r <= cls_nxt.cls;
          if (cls_nxt.skip && (skip_r != {SKIP_WIDTH{1'b1}})) begin
            skip_r <= skip_r + 1'b1;
          end
          state_r <= S_ACC;
        end
        S_ACC: begin
          case (cls_r)
            CLS_UNIQUE: unique_r <= acc_sat;
            CLS_SHARED: shared_r <= acc_sat;
            CLS_ROOT:   root_r   <= acc_sat;
            default:    ;
          endcase
          state_r <= last_r ? S_DEN1 : S_IDLE;
        end
        S_DEN1: begin
          den_r   <= den_sat;
          state_r <= S_DEN2;
        end
        S_DEN2: begin
          den_r   <= den_sat;
          state_r <= S_QINIT;
        end
        S_QINIT: begin
          cnt_r <= '0;
          if (den_r == '0) begin
            undef_r <= 1'b1;
            q_r     <= '0;
            state_r <= S_DONE;
          end else begin
            undef_r <= 1'b0;
            q_r     <= {{FRAC_BITS{1'b0}}, alu_res[DENW]};
            rem_r   <= alu_res[DENW] ? alu_res[DENW-1:0] : DENW'(unique_r);
            state_r <= S_ROOM;
          end
        end
        S_ROOM: begin
          room_r  <= alu_res[DENW-1:0];
          state_r <= S_STEP;
        end
        S_STEP: begin
          // rem >= den - rem is the same test as 2*rem >= den
          if (alu_res[DENW]) begin
            rem_r <= alu_res[DENW-1:0];
          end else begin
            rem_r <= {rem_r[DENW-2:0], 1'b0};
          end
          q_r   <= {q_r[FRAC_BITS-1:0], alu_res[DENW]};
          cnt_r <= cnt_r + 1'b1;
          if (cnt_r == CNTW'(FRAC_BITS - 1)) begin
            state_r <= S_DONE;
          end else begin
            state_r <= S_ROOM;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r     <= 1'b1;
            out_distance_r  <= q_r;
            out_undefined_r <= undef_r;
            out_skip_r      <= skip_r;
            unique_r        <= '0;
            shared_r        <= '0;
            root_r          <= '0;
            skip_r          <= '0;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distance       = out_distance_r;
  assign out_undefined      = out_undefined_r;
  assign out_skipped_splits = out_skip_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input taken while a split is in work");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_undefined) |-> (out_distance == '0))
    else $error("undefined request with nonzero distance");

  a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_distance <= (FRAC_BITS + 1)'(1 << FRAC_BITS)))
    else $error("distance above one");

  a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && out_free) |=>
      (unique_r == '0 && shared_r == '0 && root_r == '0 && skip_r == '0 && out_valid))
    else $error("sums not cleared after request posted");

endmodule

[test/unifrac_pair_checker.sv]
module unifrac_pair_checker
  import uusa_pkg::*;
#(
  parameter int COUNT_WIDTH = 32,
  parameter int ACC_WIDTH   = 48,
  parameter int FRAC_BITS   = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_a,
  input  logic [FIELD_WIDTH-1:0]  in_total_a,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_b,
  input  logic [FIELD_WIDTH-1:0]  in_total_b,
  input  logic [FIELD_WIDTH-1:0]  in_left_count_out,
  input  logic [FIELD_WIDTH-1:0]  in_total_out,
  input  logic [TAXA_WIDTH-1:0]   in_taxa_left,
  input  logic [TAXA_WIDTH-1:0]   in_taxa_right,
  input  logic [WEIGHT_WIDTH-1:0] in_split_weight,
  input  logic                    in_last_split,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [FRAC_BITS:0]      out_distance,
  input  logic                    out_undefined,
  input  logic [SKIP_WIDTH-1:0]   out_skipped_splits,
  output int                      errors,
  output int                      pending
);

  typedef struct packed {
    logic [FRAC_BITS:0]    distance;
    logic                  undefined;
    logic [SKIP_WIDTH-1:0] skipped;
  } pair_result_t;

  localparam logic [63:0] CNT_MASK = {64{1'b1}} >> (64 - COUNT_WIDTH);

  logic [ACC_WIDTH-1:0]  unique_acc;
  logic [ACC_WIDTH-1:0]  shared_acc;
  logic [ACC_WIDTH-1:0]  root_acc;
  logic [SKIP_WIDTH-1:0] skip_acc;
  pair_result_t          distance_q[$];
  int                    fails;

  function automatic longint as_count(input logic [FIELD_WIDTH-1:0] v);
    return longint'(64'(v) & CNT_MASK);
  endfunction

  function automatic logic [ACC_WIDTH-1:0] acc_add(input logic [ACC_WIDTH-1:0] acc,
                                                   input logic [WEIGHT_WIDTH-1:0] w);
    logic [ACC_WIDTH:0] s;
    s = {1'b0, acc} + w;
    return s[ACC_WIDTH] ? {ACC_WIDTH{1'b1}} : s[ACC_WIDTH-1:0];
  endfunction

  // orient by the outgroup side, then classify against the ingroup side
  function automatic split_class_t judge(input longint la, ra, lb, rb, lo, ro, xl, xr);
    split_class_t c;
    longint       ing;
    c.skip = 1'b0;
    c.cls  = CLS_NONE;
    if (lo > 0 && ro > 0) begin
      c.skip = 1'b1;
    end else if (lo > 0) begin
      ing = xl - lo;
      if ((ra > 0 && rb == 0) || (ra == 0 && rb > 0)) c.cls = CLS_UNIQUE;
      else if (ra > 0 && rb > 0 && la + lb > 0) c.cls = CLS_SHARED;
      else if (la == 0 && lb == 0 && ing > 0) c.cls = CLS_ROOT;
    end else if (ro > 0) begin
      ing = xr - ro;
      if ((la > 0 && lb == 0) || (la == 0 && lb > 0)) c.cls = CLS_UNIQUE;
      else if (la > 0 && lb > 0 && ra + rb > 0) c.cls = CLS_SHARED;
      else if (ra == 0 && rb == 0 && ing > 0) c.cls = CLS_ROOT;
    end
    return c;
  endfunction

  task automatic clear_sums();
    unique_acc = '0;
    shared_acc = '0;
    root_acc   = '0;
    skip_acc   = '0;
  endtask

  task automatic take_split();
    split_class_t c;
    logic [65:0]  den_wide;
    logic [63:0]  den;
    logic [127:0] quot;
    pair_result_t r;
    c = judge(as_count(in_left_count_a), as_count(in_total_a) - as_count(in_left_count_a),
              as_count(in_left_count_b), as_count(in_total_b) - as_count(in_left_count_b),
              as_count(in_left_count_out),
              as_count(in_total_out) - as_count(in_left_count_out),
              longint'(in_taxa_left), longint'(in_taxa_right));
    if (c.skip) begin
      if (skip_acc != {SKIP_WIDTH{1'b1}}) skip_acc++;
    end else begin
      case (c.cls)
        CLS_UNIQUE: unique_acc = acc_add(unique_acc, in_split_weight);
        CLS_SHARED: shared_acc = acc_add(shared_acc, in_split_weight);
        CLS_ROOT:   root_acc   = acc_add(root_acc, in_split_weight);
        default: ;
      endcase
    end
    if (in_last_split) begin
      den_wide = 66'(unique_acc) + 66'(shared_acc) + 66'(root_acc);
      den = (|den_wide[65:64]) ? {64{1'b1}} : den_wide[63:0];
      r.undefined = (den == 64'd0);
      r.skipped   = skip_acc;
      if (den == 64'd0) begin
        r.distance = '0;
      end else begin
        quot = (128'(unique_acc) << FRAC_BITS) / 128'(den);
        r.distance = quot[FRAC_BITS:0];
      end
      distance_q = {distance_q, r};
      clear_sums();
    end
  endtask

  task automatic check_result();
    pair_result_t want;
    if (distance_q.size() == 0) begin
      fails++;
      $display("%0t: unexpected result request: distance %0d undefined %0b skipped %0d",
               $time, out_distance, out_undefined, out_skipped_splits);
    end else begin
      want = distance_q.pop_front();
      if (out_distance !== want.distance) begin
        fails++;
        $display("%0t: distance expected %0d actual %0d", $time, want.distance, out_distance);
      end
      if (out_undefined !== want.undefined) begin
        fails++;
        $display("%0t: undefined expected %0b actual %0b", $time, want.undefined,
                 out_undefined);
      end
      if (out_skipped_splits !== want.skipped) begin
        fails++;
        $display("%0t: skipped_splits expected %0d actual %0d", $time, want.skipped,
                 out_skipped_splits);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_sums();
      distance_q.delete();
      fails = 0;
    end else begin
      if (out_valid && !out_stall) check_result();
      if (in_valid && !in_stall) take_split();
    end
    errors  <= fails;
    pending <= distance_q.size();
  end

endmodule

[test/tb_unweighted_unifrac_split_accumulator_core.sv]
module tb_unweighted_unifrac_split_accumulator_core;
  import uusa_pkg::*;

  typedef enum {K_UNIQUE, K_SHARED, K_ROOT, K_SKIP, K_BARE, K_OPEN, K_NOISE} split_kind_t;
  typedef enum {STALL_NONE, STALL_COIN, STALL_HEAVY, STALL_HOLD} stall_mode_t;

  typedef struct {
    logic [FIELD_WIDTH-1:0]  left_a;
    logic [FIELD_WIDTH-1:0]  total_a;
    logic [FIELD_WIDTH-1:0]  left_b;
    logic [FIELD_WIDTH-1:0]  total_b;
    logic [FIELD_WIDTH-1:0]  left_out;
    logic [FIELD_WIDTH-1:0]  total_out;
    logic [TAXA_WIDTH-1:0]   taxa_l;
    logic [TAXA_WIDTH-1:0]   taxa_r;
    logic [WEIGHT_WIDTH-1:0] weight;
    logic                    last;
  } split_t;

  localparam int RANDOM_SPLITS = 1890;
  localparam int SAT_SPLITS    = 20;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 100;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic [FIELD_WIDTH-1:0]  in_left_count_a;
  logic [FIELD_WIDTH-1:0]  in_total_a;
  logic [FIELD_WIDTH-1:0]  in_left_count_b;
  logic [FIELD_WIDTH-1:0]  in_total_b;
  logic [FIELD_WIDTH-1:0]  in_left_count_out;
  logic [FIELD_WIDTH-1:0]  in_total_out;
  logic [TAXA_WIDTH-1:0]   in_taxa_left;
  logic [TAXA_WIDTH-1:0]   in_taxa_right;
  logic [WEIGHT_WIDTH-1:0] in_split_weight;
  logic                    in_last_split;
  logic                    out_valid;
  logic                    out_stall;
  logic [16:0]             out_distance;
  logic                    out_undefined;
  logic [SKIP_WIDTH-1:0]   out_skipped_splits;
  int                      errors;
  int                      pending;
  bit                      idle_on;
  int                      burst_left;

  wire took = (in_valid && !in_stall) || (out_valid && !out_stall);

  unweighted_unifrac_split_accumulator_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_count_a    (in_left_count_a),
    .in_total_a         (in_total_a),
    .in_left_count_b    (in_left_count_b),
    .in_total_b         (in_total_b),
    .in_left_count_out  (in_left_count_out),
    .in_total_out       (in_total_out),
    .in_taxa_left       (in_taxa_left),
    .in_taxa_right      (in_taxa_right),
    .in_split_weight    (in_split_weight),
    .in_last_split      (in_last_split),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distance       (out_distance),
    .out_undefined      (out_undefined),
    .out_skipped_splits (out_skipped_splits)
  );

  unifrac_pair_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_left_count_a    (in_left_count_a),
    .in_total_a         (in_total_a),
    .in_left_count_b    (in_left_count_b),
    .in_total_b         (in_total_b),
    .in_left_count_out  (in_left_count_out),
    .in_total_out       (in_total_out),
    .in_taxa_left       (in_taxa_left),
    .in_taxa_right      (in_taxa_right),
    .in_split_weight    (in_split_weight),
    .in_last_split      (in_last_split),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_distance       (out_distance),
    .out_undefined      (out_undefined),
    .out_skipped_splits (out_skipped_splits),
    .errors             (errors),
    .pending            (pending)
  );

  function automatic logic [FIELD_WIDTH-1:0] cnt_pos();
    logic [FIELD_WIDTH-1:0] v;
    case ($urandom_range(0, 9))
      5: v = $urandom_range(1, 1000);
      6, 7: begin
        v = $urandom;
        if (v == '0) v = 1;
      end
      8: v = {FIELD_WIDTH{1'b1}};
      9: v = {1'b1, 31'($urandom)};
      default: v = $urandom_range(1, 8);
    endcase
    return v;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] rand_cnt();
    return ($urandom_range(0, 3) == 0) ? '0 : cnt_pos();
  endfunction

  function automatic logic [TAXA_WIDTH-1:0] rand_taxa();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return {TAXA_WIDTH{1'b1}};
      2, 3: return TAXA_WIDTH'($urandom);
      default: return TAXA_WIDTH'($urandom_range(0, 50));
    endcase
  endfunction

  function automatic logic [WEIGHT_WIDTH-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return {WEIGHT_WIDTH{1'b1}};
      2, 3: return $urandom_range(1, 32'h30000);
      default: return $urandom;
    endcase
  endfunction

  // left/total pair with the presence asked on each side
  function automatic void split_counts(input bit lpos, input bit rpos,
                                       output logic [FIELD_WIDTH-1:0] l,
                                       output logic [FIELD_WIDTH-1:0] t);
    if (lpos && rpos) begin
      t = cnt_pos();
      if (t < 2) t = 2;
      l = $urandom_range(t - 1, 1);
    end else if (lpos) begin
      l = cnt_pos();
      t = l;
    end else if (rpos) begin
      l = '0;
      t = cnt_pos();
    end else begin
      l = '0;
      t = '0;
    end
  endfunction

  // x = presence on the outgroup side, y = presence on the ingroup side
  function automatic split_t make_split(input split_kind_t k);
    split_t      s;
    bit          ax, ay, bx, by, out_left;
    int unsigned depth;
    s.taxa_l = rand_taxa();
    s.taxa_r = rand_taxa();
    s.weight = rand_weight();
    s.last   = 1'b0;
    ax = $urandom_range(0, 1);
    ay = $urandom_range(0, 1);
    bx = $urandom_range(0, 1);
    by = $urandom_range(0, 1);
    out_left = $urandom_range(0, 1);
    case (k)
      K_UNIQUE: begin
        ay = $urandom_range(0, 1);
        by = !ay;
      end
      K_SHARED: begin
        ay = 1'b1;
        by = 1'b1;
        if (!ax && !bx) ax = 1'b1;
      end
      K_ROOT: begin
        ax = 1'b0;
        bx = 1'b0;
        ay = $urandom_range(0, 1);
        by = ay;
      end
      default: ;
    endcase
    if (out_left) begin
      split_counts(ax, ay, s.left_a, s.total_a);
      split_counts(bx, by, s.left_b, s.total_b);
      split_counts(1'b1, 1'b0, s.left_out, s.total_out);
    end else begin
      split_counts(ay, ax, s.left_a, s.total_a);
      split_counts(by, bx, s.left_b, s.total_b);
      split_counts(1'b0, 1'b1, s.left_out, s.total_out);
    end
    case (k)
      K_SKIP: split_counts(1'b1, 1'b1, s.left_out, s.total_out);
      K_BARE: begin
        s.left_out  = '0;
        s.total_out = '0;
      end
      K_ROOT: begin
        depth = $urandom_range(1, 5000);
        s.total_out = depth;
        s.left_out  = out_left ? depth : 0;
        if (out_left) s.taxa_l = TAXA_WIDTH'(depth + $urandom_range(0, 4) - 1);
        else s.taxa_r = TAXA_WIDTH'(depth + $urandom_range(0, 4) - 1);
      end
      K_NOISE: begin
        s.left_a  = rand_cnt();
        s.total_a = rand_cnt();
        s.left_b  = rand_cnt();
        s.total_b = rand_cnt();
        if ($urandom_range(0, 1)) begin
          s.left_out  = rand_cnt();
          s.total_out = rand_cnt();
        end
      end
      default: ;
    endcase
    return s;
  endfunction

  function automatic split_kind_t pick_kind(input bit hollow);
    int unsigned r;
    if (hollow) return $urandom_range(0, 1) ? K_SKIP : K_BARE;
    r = $urandom_range(0, 99);
    if (r < 25) return K_UNIQUE;
    if (r < 50) return K_SHARED;
    if (r < 65) return K_ROOT;
    if (r < 75) return K_SKIP;
    if (r < 80) return K_BARE;
    if (r < 92) return K_OPEN;
    return K_NOISE;
  endfunction

  function automatic split_t mk(input logic [FIELD_WIDTH-1:0] la, ta, lb, tb, lo, tot,
                                input logic [TAXA_WIDTH-1:0] xl, xr,
                                input logic [WEIGHT_WIDTH-1:0] w, input logic last);
    split_t s;
    s.left_a    = la;
    s.total_a   = ta;
    s.left_b    = lb;
    s.total_b   = tb;
    s.left_out  = lo;
    s.total_out = tot;
    s.taxa_l    = xl;
    s.taxa_r    = xr;
    s.weight    = w;
    s.last      = last;
    return s;
  endfunction

  task automatic drive(input split_t s);
    in_left_count_a   <= s.left_a;
    in_total_a        <= s.total_a;
    in_left_count_b   <= s.left_b;
    in_total_b        <= s.total_b;
    in_left_count_out <= s.left_out;
    in_total_out      <= s.total_out;
    in_taxa_left      <= s.taxa_l;
    in_taxa_right     <= s.taxa_r;
    in_split_weight   <= s.weight;
    in_last_split     <= s.last;
  endtask

  task automatic send_split(input split_t s);
    if (idle_on && burst_left == 0) begin
      in_valid <= 1'b0;
      drive(make_split(K_NOISE));
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    drive(s);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    stall_mode_t mode;
    int          n;
    out_stall = 1'b0;
    forever begin
      mode = stall_mode_t'($urandom_range(0, 3));
      n = $urandom_range(1, 60);
      repeat (n) begin
        @(posedge clk);
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_COIN:  out_stall <= ($urandom_range(0, 1) == 1);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
          default:     out_stall <= 1'b1;
        endcase
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (took) idle = 0;
      else idle++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    split_t s;
    int     plen;
    int     random_sent;
    bit     hollow;
    random_sent = 0;
    idle_on     = 1'b0;
    burst_left  = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    drive(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // no outgroup at all; everything at its maximum
    send_split(mk(0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 1));
    send_split(mk('1, '1, '1, '1, '1, '1, '1, '1, '1, 1));
    // unique on the right, shared with outgroup on the right
    send_split(mk(2, 5, 4, 4, 1, 1, 7, 9, 32'hFFFF_FFFF, 0));
    send_split(mk(1, 3, 2, 2, 0, 7, 3, 4, 32'hFFFF_FFFF, 1));
    idle_on = 1'b1;
    // root, unique, shared at one third each
    send_split(mk(0, 0, 0, 0, 3, 3, 4, 0, 32'h10000, 0));
    send_split(mk(5, 5, 0, 9, 0, 2, 6, 1, 32'h10000, 0));
    send_split(mk(1, 2, 0, 3, 1, 1, 2, 5, 32'h10000, 1));
    // ingroup taxa zero and negative, then root with outgroup on the right
    send_split(mk(0, 0, 0, 0, 3, 3, 3, 8, 32'h1234, 0));
    send_split(mk(0, 0, 0, 0, 3, 3, 2, 8, 32'h1234, 0));
    send_split(mk(0, 0, 0, 0, 0, 5, 1, 6, 1, 1));
    // left above total, skipped splits, zero denominator
    send_split(mk(9, 3, 0, 0, 1, 1, 5, 5, 77, 0));
    send_split(mk(1, 0, 0, 0, 5, 2, 9, 9, 88, 0));
    send_split(mk(1, 1, 1, 1, 1, 2, 3, 3, 99, 0));
    send_split(mk(0, 0, 0, 0, 2, 9, 3, 3, 5, 0));
    send_split(mk(3, 3, 0, 0, 0, 4, 2, 2, 0, 1));
    // distance of one, then two thirds
    send_split(mk(0, 6, 0, 0, 4, 4, 9, 9, 32'hFFFF_FFFF, 0));
    send_split(mk(7, 7, 0, 0, 0, 1, 2, 2, 32'hFFFF_FFFF, 1));
    send_split(mk(1, 2, 1, 2, 0, 3, 5, 5, 1, 0));
    send_split(mk(0, 0, 2, 3, 1, 1, 5, 5, 2, 1));
    drain();

    // one pair of maximum weights interleaved with skipped splits
    idle_on = 1'b0;
    for (int i = 0; i < SAT_SPLITS; i++) begin
      s = make_split(K_UNIQUE);
      s.weight = '1;
      send_split(s);
      send_split(make_split(K_SKIP));
    end
    s = make_split(K_SHARED);
    s.weight = '1;
    s.last = 1'b1;
    send_split(s);
    drain();

    while (random_sent < RANDOM_SPLITS) begin
      hollow  = ($urandom_range(0, 11) == 0);
      idle_on = ($urandom_range(0, 3) != 0);
      plen = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      for (int i = 0; i < plen; i++) begin
        s = make_split(pick_kind(hollow));
        s.last = (i == plen - 1);
        send_split(s);
        random_sent++;
      end
      if ($urandom_range(0, 9) == 0) drain();
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

[unweighted_unifrac_split_accumulator_core.f]
hdl/uusa_pkg.sv
hdl/uusa_classify.sv
hdl/unweighted_unifrac_split_accumulator_core.sv
test/unifrac_pair_checker.sv
test/tb_unweighted_unifrac_split_accumulator_core.sv
